>>> rtl/bba_pkg.sv
// Shared constants and types for the bitmap block allocator.
package bba_pkg;

    localparam int MAP_ENTRIES = 65536;
    localparam int BLOCK_BASE  = 1001;
    localparam int BLOCK_BYTES = 1024;

    // Field widths of the request and response beats
    localparam int REQ_TYPE_W = 2;
    localparam int BLOCK_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 17;
    localparam int BYTES_W    = 27;

    // Three-level map: top summary bits, mid summary words, leaf words.
    // MAP_ENTRIES is expected to be WORD_BITS * WORD_BITS * k, k >= 2.
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = $clog2(MAP_ENTRIES);
    localparam int LEAF_WORDS = MAP_ENTRIES / WORD_BITS;
    localparam int LEAF_AW    = $clog2(LEAF_WORDS);
    localparam int MID_WORDS  = LEAF_WORDS / WORD_BITS;
    localparam int MID_AW     = $clog2(MID_WORDS);

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

>>> rtl/bba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if;
    import bba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BLOCK_W-1:0]    block_number;

    modport source (output valid, req_type, block_number, input ready);
    modport sink   (input valid, req_type, block_number, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  granted_block;
    logic [COUNT_W-1:0]  free_count;
    logic [BYTES_W-1:0]  free_bytes;

    modport source (output valid, status, granted_block, free_count, free_bytes,
                    input ready);
    modport sink   (input valid, status, granted_block, free_count, free_bytes,
                    output ready);
endinterface

>>> rtl/bitmap_block_allocator.sv
// Bitmap free-block allocator: three-level free map, leaf and mid levels in RAM.
//
//  channel  dir  payload                                         handshake
//  req      in   req_type, block_number                          valid/ready
//  rsp      out  status, granted_block, free_count, free_bytes   valid/ready
//
// One request at a time. Allocate steps from accept to response beat:
// top pick + mid read, leaf read, leaf/mid write-back, output load.
// Free: leaf and mid read together, write-back, output load.
// Query and rejected requests: output load only. Next accept in the cycle after the load.
// After reset the map RAM is set to all-free, one leaf word a cycle;
// req.ready stays low until all LEAF_WORDS (1024) leaf words are written.
// A response waiting on rsp.ready holds the next request in the output-load step.
module bitmap_block_allocator (
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_MID  = 5'b00100,
        S_LEAF = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    function automatic logic [BIT_W-1:0] lowest_word_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
                pos = BIT_W'(i);
        end
        return pos;
    endfunction

    function automatic logic [MID_AW-1:0] lowest_top_bit(input logic [MID_WORDS-1:0] w);
        logic [MID_AW-1:0] pos;
        pos = '0;
        for (int i = MID_WORDS - 1; i >= 0; i--)
        begin
            if (w[i])
                pos = MID_AW'(i);
        end
        return pos;
    endfunction

    // Control state
    state_t               state_reg, state_next;
    logic [LEAF_AW-1:0]   init_cnt_reg, init_cnt_next;
    logic [MID_WORDS-1:0] top_reg, top_next;
    logic [COUNT_W-1:0]   free_total_reg, free_total_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Per-request working registers
    logic                 is_alloc_reg, is_alloc_next;
    logic [LEAF_AW-1:0]   word_addr_reg, word_addr_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    status_t              res_status_reg, res_status_next;
    logic [BLOCK_W-1:0]   res_granted_reg, res_granted_next;

    // Output payload
    logic [STATUS_W-1:0]  rsp_status_reg;
    logic [BLOCK_W-1:0]   rsp_granted_reg;
    logic [COUNT_W-1:0]   rsp_count_reg;
    logic [BYTES_W-1:0]   rsp_bytes_reg;
    logic                 load_out;

    // Map memories
    logic [WORD_BITS-1:0] leaf_mem [LEAF_WORDS];
    logic [WORD_BITS-1:0] mid_mem  [MID_WORDS];
    logic [WORD_BITS-1:0] leaf_rd_reg, mid_rd_reg;
    logic                 leaf_we, mid_we;
    logic [LEAF_AW-1:0]   leaf_wa, leaf_ra;
    logic [MID_AW-1:0]    mid_wa, mid_ra;
    logic [WORD_BITS-1:0] leaf_wd, mid_wd;

    // Request decode
    logic [BLOCK_W:0]     blk_diff;
    logic                 blk_in_range;
    logic [IDX_W-1:0]     free_idx;
    logic [MID_AW-1:0]    top_sel;
    logic [BIT_W-1:0]     mid_bit, leaf_bit;
    logic [WORD_BITS-1:0] alloc_leaf_new, alloc_mid_new;
    logic [WORD_BITS-1:0] free_leaf_new, free_mid_new;

    assign blk_diff     = {1'b0, req.block_number} - (BLOCK_W + 1)'(BLOCK_BASE);
    assign blk_in_range = !blk_diff[BLOCK_W] && (blk_diff[BLOCK_W-1:0] < MAP_ENTRIES);
    assign free_idx     = blk_diff[IDX_W-1:0];
    assign top_sel      = lowest_top_bit(top_reg);
    assign mid_bit      = lowest_word_bit(mid_rd_reg);
    assign leaf_bit     = lowest_word_bit(leaf_rd_reg);

    assign alloc_leaf_new = leaf_rd_reg & ~(WORD_BITS'(1) << leaf_bit);
    assign alloc_mid_new  = mid_rd_reg & ~(WORD_BITS'(1) << word_addr_reg[BIT_W-1:0]);
    assign free_leaf_new  = leaf_rd_reg | (WORD_BITS'(1) << bit_reg);
    assign free_mid_new   = mid_rd_reg | (WORD_BITS'(1) << word_addr_reg[BIT_W-1:0]);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        top_next         = top_reg;
        free_total_next  = free_total_reg;
        is_alloc_next    = is_alloc_reg;
        word_addr_next   = word_addr_reg;
        bit_next         = bit_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        load_out         = 1'b0;

        leaf_we = 1'b0;
        leaf_wa = word_addr_reg;
        leaf_wd = alloc_leaf_new;
        leaf_ra = word_addr_reg;
        mid_we  = 1'b0;
        mid_wa  = word_addr_reg[LEAF_AW-1:BIT_W];
        mid_wd  = alloc_mid_new;
        mid_ra  = word_addr_reg[LEAF_AW-1:BIT_W];

        unique case (state_reg)
            S_INIT:
            begin
                leaf_we = 1'b1;
                leaf_wa = init_cnt_reg;
                leaf_wd = '1;
                if (init_cnt_reg < MID_WORDS)
                begin
                    mid_we = 1'b1;
                    mid_wa = init_cnt_reg[MID_AW-1:0];
                    mid_wd = '1;
                end
                init_cnt_next = init_cnt_reg + LEAF_AW'(1);
                if (init_cnt_reg == LEAF_AW'(LEAF_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // reads go out on the accept edge
                if (req.req_type == REQ_FREE)
                begin
                    mid_ra  = free_idx[IDX_W-1:IDX_W-MID_AW];
                    leaf_ra = free_idx[IDX_W-1:BIT_W];
                end
                else
                begin
                    mid_ra = top_sel;
                end
                if (req.valid)
                begin
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        is_alloc_next = 1'b1;
                        if (|top_reg)
                        begin
                            word_addr_next = {top_sel, BIT_W'(0)};
                            state_next     = S_MID;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                    end
                    else if (req.req_type == REQ_FREE)
                    begin
                        is_alloc_next = 1'b0;
                        if (blk_in_range)
                        begin
                            word_addr_next = free_idx[IDX_W-1:BIT_W];
                            bit_next       = free_idx[BIT_W-1:0];
                            state_next     = S_LEAF;
                        end
                        else
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        // query, and the unused code that behaves as one
                        state_next = S_DONE;
                    end
                end
            end
            S_MID:
            begin
                leaf_ra        = {word_addr_reg[LEAF_AW-1:BIT_W], mid_bit};
                word_addr_next = {word_addr_reg[LEAF_AW-1:BIT_W], mid_bit};
                state_next     = S_LEAF;
            end
            S_LEAF:
            begin
                if (is_alloc_reg)
                begin
                    leaf_we = 1'b1;
                    leaf_wd = alloc_leaf_new;
                    if (alloc_leaf_new == '0)
                    begin
                        mid_we = 1'b1;
                        mid_wd = alloc_mid_new;
                        if (alloc_mid_new == '0)
                            top_next[word_addr_reg[LEAF_AW-1:BIT_W]] = 1'b0;
                    end
                    free_total_next  = free_total_reg - COUNT_W'(1);
                    res_granted_next = BLOCK_W'({word_addr_reg, leaf_bit})
                                     + BLOCK_W'(BLOCK_BASE);
                end
                else if (!leaf_rd_reg[bit_reg])
                begin
                    // only a used block changes the count
                    leaf_we = 1'b1;
                    leaf_wd = free_leaf_new;
                    mid_we  = 1'b1;
                    mid_wd  = free_mid_new;
                    top_next[word_addr_reg[LEAF_AW-1:BIT_W]] = 1'b1;
                    free_total_next = free_total_reg + COUNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            top_reg        <= '1;
            free_total_reg <= COUNT_W'(MAP_ENTRIES);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            top_reg        <= top_next;
            free_total_reg <= free_total_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_alloc_reg    <= is_alloc_next;
        word_addr_reg   <= word_addr_next;
        bit_reg         <= bit_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        if (load_out)
        begin
            rsp_status_reg  <= res_status_reg;
            rsp_granted_reg <= res_granted_reg;
            rsp_count_reg   <= free_total_reg;
            rsp_bytes_reg   <= BYTES_W'(free_total_reg * BLOCK_BYTES);
        end
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_wa] <= leaf_wd;
        leaf_rd_reg <= leaf_mem[leaf_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
            mid_mem[mid_wa] <= mid_wd;
        mid_rd_reg <= mid_mem[mid_ra];
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.granted_block = rsp_granted_reg;
    assign rsp.free_count    = rsp_count_reg;
    assign rsp.free_bytes    = rsp_bytes_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= COUNT_W'(MAP_ENTRIES))
        else $error("free count above map size");

    a_top_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg == '0) == (free_total_reg == '0))
        else $error("top summary disagrees with free count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.free_count == '0))
        else $error("full reported with free blocks left");

    a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAF && is_alloc_reg)
            |=> (free_total_reg == $past(free_total_reg) - COUNT_W'(1)))
        else $error("allocate did not take one block");

endmodule
